// ===== hdl/egb_pkg.sv =====
// ----------------------------------------------------------------------------
// egb_pkg: shared types and constants of the epsilon-greedy bandit weights
// Table sizes, field widths, register reset values and the sequencer states.
// ----------------------------------------------------------------------------
package egb_pkg;

    localparam int LAYERS    = 4;
    localparam int POSITIONS = 256;
    localparam int MAX_ARMS  = 16;

    localparam int LAYER_W = 2;
    localparam int POS_W   = 8;
    localparam int ARM_W   = 4;
    localparam int SLOT_W  = LAYER_W + POS_W;
    localparam int VAL_AW  = SLOT_W + ARM_W;
    localparam int VAL_W   = 16;
    localparam int CNT_W   = 5;
    localparam int RATE_W  = 16;
    localparam int WGT_W   = 15;

    localparam int DIV_NUM_W = 21;
    localparam int DIV_DEN_W = 6;
    localparam int QUOT_W    = 16;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    localparam logic [CNT_W-1:0]  ARM_COUNT_RST    = 5'd16;
    localparam logic [RATE_W-1:0] LEARN_RATE_RST   = 16'd6554;
    localparam logic [RATE_W-1:0] EXPLORE_RATE_RST = 16'd6554;
    localparam logic [RATE_W-1:0] PLAY_ROUNDS_RST  = 16'd0;
    localparam logic [QUOT_W-1:0] WEIGHT_OFFSET    = 16'd16384;

    typedef enum logic [1:0] {
        CFG_ARM_COUNT,
        CFG_LEARN_RATE,
        CFG_EXPLORE_RATE,
        CFG_PLAY_ROUNDS
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARM_RD,
        S_VAL_RD,
        S_MUL,
        S_UPD,
        S_SCAN,
        S_DIVGO,
        S_DIV,
        S_OUT
    } t_state;

    // Arms in use: zero acts as one, anything above the table size is capped.
    function automatic logic [CNT_W-1:0] arms_in_use(input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] n;
        n = count;
        if (count == '0) begin
            n = CNT_W'(1);
        end else if (32'(count) > MAX_ARMS) begin
            n = CNT_W'(MAX_ARMS);
        end
        return n;
    endfunction

endpackage

// ===== hdl/egb_ram.sv =====
// ----------------------------------------------------------------------------
// egb_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module egb_ram #(
    parameter int AW = 10,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/egb_div.sv =====
// ----------------------------------------------------------------------------
// egb_div: radix-2 restoring divider for the weight computation
// Produces a 16-bit quotient one bit per cycle; the quotient must fit 16 bits.
// ----------------------------------------------------------------------------
module egb_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [egb_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [egb_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [egb_pkg::QUOT_W-1:0]     o_quot
);

    localparam int DW = egb_pkg::DIV_DEN_W;
    localparam int QW = egb_pkg::QUOT_W;
    localparam int KW = $clog2(QW + 1);

    logic [DW-1:0] r_rem, n_rem;
    logic [QW-1:0] r_q, n_q;
    logic [DW-1:0] r_den;
    logic [KW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_trial;
    logic          w_ge;

    assign w_trial = {r_rem, r_q[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_rem = w_trial[DW-1:0];
        if (w_ge) begin
            n_rem = DW'(w_trial - {1'b0, r_den});
        end
        n_q = {r_q[QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + KW'(1);
                if (r_cnt == KW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DW'(i_num[egb_pkg::DIV_NUM_W-1:QW]);
            r_q   <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hdl/epsilon_greedy_bandit_weights_top.sv =====
// ----------------------------------------------------------------------------
// epsilon_greedy_bandit_weights_top: epsilon-greedy bandit weight selector
//
//   Channel  Direction  Beat contents
//   s_axis   in         tdata: layer, position, reward, grad_positive,
//                       random_draw; tlast: round_end
//   m_axis   out        tdata: arm_index, weight_value; tuser: weight_written
//   cfg      in         index and data of one register write
//
// After reset the tables are swept to zero; items wait.
// An in-range non-selection beat passes the arm read, value read, multiply and
// update steps; an exploring selection adds the weight divide, and an exploiting
// selection adds an argmax before it: the argmax reads one arm value a cycle from
// the value memory and the weight divider runs 16 steps. One item is in work at
// a time; a stalled output holds one result while the next item is accepted.
// ----------------------------------------------------------------------------
module epsilon_greedy_bandit_weights_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // layer[1:0], position[9:2], reward[25:10], grad_positive[26],
    // random_draw[42:27], zero fill above
    input  logic [egb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // arm_index[3:0], weight_value[18:4], zero fill above
    output logic [egb_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // weight_written[0]
    output logic                            m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [egb_pkg::RATE_W-1:0]      i_cfg_data
);

    localparam int SW = egb_pkg::SLOT_W;
    localparam int AW = egb_pkg::ARM_W;
    localparam int VW = egb_pkg::VAL_W;
    localparam int CW = egb_pkg::CNT_W;
    localparam int RW = egb_pkg::RATE_W;
    localparam int QW = egb_pkg::QUOT_W;
    localparam int CLR_W = egb_pkg::VAL_AW + 1;

    // configuration
    logic [CW-1:0] r_arm_count;
    logic [RW-1:0] r_learn, r_explore_rate, r_play;
    logic [CW-1:0] w_n;

    // sequencer
    egb_pkg::t_state r_state, n_state;
    logic            r_clearing;
    logic [CLR_W-1:0] r_clr_cnt;
    logic [RW-1:0]   r_timer;

    // item registers
    logic [SW-1:0]   r_slot;
    logic signed [VW-1:0] r_reward;
    logic            r_grad;
    logic            r_explore;
    logic            r_select;
    logic            r_in_range;
    logic [AW-1:0]   r_arm;
    logic signed [VW-1:0] r_val;
    logic signed [2*VW+1:0] r_prod;
    logic [CW-1:0]   r_scan_idx;
    logic [CW-1:0]   r_cmp_idx;
    logic            r_cmp_valid;
    logic signed [VW-1:0] r_best_val;
    logic [AW-1:0]   r_best_idx;
    logic [QW-1:0]   r_weight;

    // output register
    logic            r_out_valid;
    logic            r_out_written;
    logic [AW-1:0]   r_out_arm;
    logic [egb_pkg::WGT_W-1:0] r_out_weight;

    // memories
    logic                       w_val_we;
    logic [egb_pkg::VAL_AW-1:0] w_val_waddr, w_val_raddr;
    logic [VW-1:0]              w_val_wdata, w_val_rdata;
    logic                       w_arm_we;
    logic [SW-1:0]              w_arm_waddr;
    logic [AW-1:0]              w_arm_wdata, w_arm_rdata;

    // divider
    logic                           w_div_start, w_div_done;
    logic [egb_pkg::DIV_NUM_W-1:0]  w_div_num;
    logic [egb_pkg::DIV_DEN_W-1:0]  w_div_den;
    logic [QW-1:0]                  w_div_quot;

    // datapath
    logic                 w_s_acc, w_m_acc, w_out_load;
    logic                 w_sel_now;
    logic [RW-1:0]        w_timer_ld;
    logic signed [VW:0]   w_diff;
    logic signed [2*VW+1:0] w_round;
    logic signed [VW+2:0] w_nv;
    logic [VW-1:0]        w_nv_sat;
    logic signed [CW+1:0] w_step;
    logic [AW-1:0]        w_explore_arm;
    logic                 w_take;
    logic                 w_scan_last;
    logic [AW-1:0]        w_best_final;

    assign w_n = egb_pkg::arms_in_use(r_arm_count);

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == egb_pkg::S_IDLE) && !r_clearing;
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_m_acc       = r_out_valid && m_axis_tready;
    assign w_out_load    = (r_state == egb_pkg::S_OUT) && (!r_out_valid || m_axis_tready);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_count    <= egb_pkg::ARM_COUNT_RST;
            r_learn        <= egb_pkg::LEARN_RATE_RST;
            r_explore_rate <= egb_pkg::EXPLORE_RATE_RST;
            r_play         <= egb_pkg::PLAY_ROUNDS_RST;
        end else if (i_cfg_valid) begin
            unique case (egb_pkg::t_cfg_index'(i_cfg_index))
                egb_pkg::CFG_ARM_COUNT:    r_arm_count    <= i_cfg_data[CW-1:0];
                egb_pkg::CFG_LEARN_RATE:   r_learn        <= i_cfg_data;
                egb_pkg::CFG_EXPLORE_RATE: r_explore_rate <= i_cfg_data;
                egb_pkg::CFG_PLAY_ROUNDS:  r_play         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- clearing sweep and round timer ----------------
    assign w_sel_now  = (r_timer == '0);
    assign w_timer_ld = w_sel_now ? r_play : r_timer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
            r_timer    <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
                if (r_clr_cnt == CLR_W'((1 << egb_pkg::VAL_AW) - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (w_s_acc && s_axis_tlast) begin
                r_timer <= (w_timer_ld != '0) ? w_timer_ld - RW'(1) : w_timer_ld;
            end
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            egb_pkg::S_IDLE: begin
                if (w_s_acc) begin
                    n_state = egb_pkg::S_ARM_RD;
                end
            end
            egb_pkg::S_ARM_RD: begin
                n_state = r_in_range ? egb_pkg::S_VAL_RD : egb_pkg::S_OUT;
            end
            egb_pkg::S_VAL_RD: n_state = egb_pkg::S_MUL;
            egb_pkg::S_MUL:    n_state = egb_pkg::S_UPD;
            egb_pkg::S_UPD: begin
                if (!r_select) begin
                    n_state = egb_pkg::S_OUT;
                end else if (r_explore) begin
                    n_state = egb_pkg::S_DIVGO;
                end else begin
                    n_state = egb_pkg::S_SCAN;
                end
            end
            egb_pkg::S_SCAN: begin
                if (w_scan_last) begin
                    n_state = egb_pkg::S_DIVGO;
                end
            end
            egb_pkg::S_DIVGO: n_state = egb_pkg::S_DIV;
            egb_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = egb_pkg::S_OUT;
                end
            end
            egb_pkg::S_OUT: begin
                if (w_out_load) begin
                    n_state = egb_pkg::S_IDLE;
                end
            end
            default: n_state = egb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= egb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- memory and divider controls ----------------
    assign w_scan_last  = r_cmp_valid && (r_cmp_idx == w_n - CW'(1));
    assign w_take       = (r_cmp_idx == '0) || ($signed(w_val_rdata) > r_best_val);
    assign w_best_final = w_take ? r_cmp_idx[AW-1:0] : r_best_idx;

    always_comb begin
        w_val_we    = 1'b0;
        w_val_waddr = {r_slot, r_arm};
        w_val_wdata = w_nv_sat;
        w_val_raddr = {r_slot, w_arm_rdata};
        w_arm_we    = 1'b0;
        w_arm_waddr = r_slot;
        w_arm_wdata = r_arm;
        w_div_start = 1'b0;
        unique case (r_state)
            egb_pkg::S_UPD:   w_val_we    = 1'b1;
            egb_pkg::S_SCAN:  w_val_raddr = {r_slot, r_scan_idx[AW-1:0]};
            egb_pkg::S_DIVGO: begin
                w_arm_we    = 1'b1;
                w_div_start = 1'b1;
            end
            default: ;
        endcase
        if (r_clearing) begin
            w_val_we    = 1'b1;
            w_val_waddr = r_clr_cnt[egb_pkg::VAL_AW-1:0];
            w_val_wdata = '0;
            w_arm_we    = 1'b1;
            w_arm_waddr = r_clr_cnt[SW-1:0];
            w_arm_wdata = '0;
        end
    end

    assign w_div_num = ((egb_pkg::DIV_NUM_W'(r_arm) + egb_pkg::DIV_NUM_W'(1)) << QW)
                     + egb_pkg::DIV_NUM_W'(w_n) + egb_pkg::DIV_NUM_W'(1);
    assign w_div_den = egb_pkg::DIV_DEN_W'({w_n, 1'b0}) + egb_pkg::DIV_DEN_W'(2);

    // ---------------- arithmetic ----------------
    assign w_diff   = $signed({r_reward[VW-1], r_reward})
                    - $signed({w_val_rdata[VW-1], w_val_rdata});
    assign w_round  = r_prod + (2*VW+2)'(32768);
    assign w_nv     = $signed({{3{r_val[VW-1]}}, r_val}) + $signed(w_round[2*VW+1:VW]);

    always_comb begin
        w_nv_sat = w_nv[VW-1:0];
        if (w_nv > (VW+3)'(32767)) begin
            w_nv_sat = 16'h7FFF;
        end else if (w_nv < -(VW+3)'(32768)) begin
            w_nv_sat = 16'h8000;
        end
    end

    always_comb begin
        w_step = $signed({3'b000, r_arm}) + (r_grad ? (CW+2)'(1) : -(CW+2)'(1));
        if (w_step > $signed({2'b00, w_n}) - (CW+2)'(1)) begin
            w_step = $signed({2'b00, w_n}) - (CW+2)'(1);
        end
        if (w_step < (CW+2)'(0)) begin
            w_step = '0;
        end
        w_explore_arm = w_step[AW-1:0];
    end

    // ---------------- item datapath ----------------
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_slot     <= s_axis_tdata[SW-1:0];
            r_reward   <= s_axis_tdata[SW+VW-1:SW];
            r_grad     <= s_axis_tdata[SW+VW];
            r_explore  <= s_axis_tdata[SW+VW+RW:SW+VW+1] < r_explore_rate;
            r_select   <= w_sel_now;
            r_in_range <= (32'(s_axis_tdata[egb_pkg::LAYER_W-1:0]) < egb_pkg::LAYERS)
                       && (32'(s_axis_tdata[SW-1:egb_pkg::LAYER_W]) < egb_pkg::POSITIONS);
        end
        unique case (r_state)
            egb_pkg::S_VAL_RD: r_arm <= w_arm_rdata;
            egb_pkg::S_MUL: begin
                r_val  <= $signed(w_val_rdata);
                r_prod <= w_diff * $signed({1'b0, r_learn});
            end
            egb_pkg::S_UPD: begin
                r_scan_idx  <= '0;
                r_cmp_valid <= 1'b0;
                if (r_select && r_explore) begin
                    r_arm <= w_explore_arm;
                end
            end
            egb_pkg::S_SCAN: begin
                r_cmp_valid <= (r_scan_idx < w_n);
                r_cmp_idx   <= r_scan_idx;
                if (r_scan_idx < w_n) begin
                    r_scan_idx <= r_scan_idx + CW'(1);
                end
                if (r_cmp_valid && w_take) begin
                    r_best_val <= $signed(w_val_rdata);
                    r_best_idx <= r_cmp_idx[AW-1:0];
                end
                if (w_scan_last) begin
                    r_arm <= w_best_final;
                end
            end
            egb_pkg::S_DIV: begin
                if (w_div_done) begin
                    r_weight <= w_div_quot - egb_pkg::WEIGHT_OFFSET;
                end
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_m_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_written <= r_select && r_in_range;
            r_out_arm     <= r_in_range ? r_arm : '0;
            r_out_weight  <= (r_select && r_in_range) ? r_weight[egb_pkg::WGT_W-1:0] : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_written;
    assign m_axis_tdata  = {(egb_pkg::M_TDATA_W - AW - egb_pkg::WGT_W)'(0),
                            r_out_weight, r_out_arm};

    // ---------------- instances ----------------
    egb_ram #(.AW(egb_pkg::VAL_AW), .DW(VW)) u_val_ram (
        .i_clk  (i_clk),
        .i_we   (w_val_we),
        .i_waddr(w_val_waddr),
        .i_wdata(w_val_wdata),
        .i_raddr(w_val_raddr),
        .o_rdata(w_val_rdata)
    );

    egb_ram #(.AW(SW), .DW(AW)) u_arm_ram (
        .i_clk  (i_clk),
        .i_we   (w_arm_we),
        .i_waddr(w_arm_waddr),
        .i_wdata(w_arm_wdata),
        .i_raddr(r_slot),
        .o_rdata(w_arm_rdata)
    );

    egb_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (w_div_den),
        .o_done (w_div_done),
        .o_quot (w_div_quot)
    );

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> (r_state != egb_pkg::S_IDLE))
        else $error("sequencer idle right after an accepted beat");

    a_arm_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == egb_pkg::S_DIVGO) |-> ({1'b0, r_arm} < w_n))
        else $error("selected arm outside the arms in use");

    a_div_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == egb_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (r_state == egb_pkg::S_IDLE) && !s_axis_tready)
        else $error("item work during the clearing sweep");

endmodule
